[rtl/brwo_pkg.sv]
// package for the overwriting broadcast ring: sizes, command codes, slot write request,
// and byte masking helpers
// no dependencies
package brwo_pkg;

    localparam int DEPTH         = 16;   // must be a power of two, slot index is seq[SLOT_W-1:0]
    localparam int SLOT_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int NUM_SUBS      = 4;
    localparam int SUB_W         = 2;
    localparam int MAX_MSG_BYTES = 8;
    localparam int SEQ_W         = 32;
    localparam int DATA_W        = 64;
    localparam int LEN_W         = 4;

    typedef enum logic [1:0] {
        CMD_PUBLISH = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_NEXT    = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } t_slot_wr;

    // clamp a length to the largest message size
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        begin
            res = len;
            if (len > LEN_W'(MAX_MSG_BYTES)) begin
                res = LEN_W'(MAX_MSG_BYTES);
            end
            return res;
        end
    endfunction

    // keep only the low len bytes of a word
    function automatic logic [DATA_W-1:0] keep_bytes(input logic [DATA_W-1:0] word,
                                                    input logic [LEN_W-1:0] len);
        logic [DATA_W-1:0] res;
        begin
            res = '0;
            for (int b = 0; b < DATA_W / 8; b++) begin
                if (LEN_W'(b) < len) begin
                    res[b*8 +: 8] = word[b*8 +: 8];
                end
            end
            return res;
        end
    endfunction

endpackage

[rtl/brwo_slots.sv]
// slot storage of the broadcast ring: message word and length per slot
// one write port, one asynchronous read port; uses brwo_pkg
module brwo_slots
    import brwo_pkg::*;
(
    input  logic              i_clk,
    input  t_slot_wr          i_wr,
    input  logic [SLOT_W-1:0] i_rd_idx,
    output logic [DATA_W-1:0] o_rd_data,
    output logic [LEN_W-1:0]  o_rd_len
);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [LEN_W-1:0]  r_len  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_data[i_wr.idx] <= i_wr.data;
            r_len[i_wr.idx]  <= i_wr.len;
        end
    end

    assign o_rd_data = r_data[i_rd_idx];
    assign o_rd_len  = r_len[i_rd_idx];

endmodule

[rtl/broadcast_ring_with_overwrite.sv]
// overwriting broadcast ring with per-subscriber read positions, top level
// depends on brwo_pkg and brwo_slots
//
// usage
// - input channel (i_in_valid / o_in_stall) takes one command transaction:
//   publish appends a message, begin moves a subscriber to the oldest held
//   message, next delivers the subscriber's next message
// - output channel (o_out_valid / i_out_stall) returns exactly one result
//   transaction per command, in command order
// - a command sits in the input register until the output register is free,
//   then executes against the ring state and its result lands in the output
//   register, where o_out_valid rises
// - throughput is one command per cycle while the receiver does not stall;
//   the ring state is updated in the same cycle the result is registered,
//   so a following command always sees it
// - when the receiver stalls, the result holds in the output register and
//   the input register keeps one more command, then o_in_stall rises
// - after reset the ring is empty, head and tail sequence are one and every
//   read position is one; slot contents are not cleared, only written slots
//   are ever read
module broadcast_ring_with_overwrite
    import brwo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic [SUB_W-1:0]  i_subscriber,
    input  logic [DATA_W-1:0] i_msg_data,
    input  logic [LEN_W-1:0]  i_msg_length,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_ok,
    output logic [DATA_W-1:0] o_out_data,
    output logic [LEN_W-1:0]  o_out_length,
    output logic [SEQ_W-1:0]  o_drop_count
);

    // input register
    logic              r_in_vld;
    logic [1:0]        r_cmd;
    logic [SUB_W-1:0]  r_sub;
    logic [DATA_W-1:0] r_data;
    logic [LEN_W-1:0]  r_len;

    // ring state: tail sequence and held count, head is derived
    logic [SEQ_W-1:0]  r_tail_seq, n_tail_seq;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SEQ_W-1:0]  r_pos [NUM_SUBS];
    logic [SEQ_W-1:0]  n_pos [NUM_SUBS];

    // result register
    logic              r_out_vld;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic [LEN_W-1:0]  r_out_len, n_out_len;
    logic [SEQ_W-1:0]  r_drop, n_drop;

    logic              out_free;
    logic              fire;
    logic              in_take;
    logic [SEQ_W-1:0]  head_seq;
    logic [SEQ_W-1:0]  sel_pos;
    logic [SEQ_W-1:0]  lag;
    logic              stale;
    logic [SEQ_W-1:0]  fix_pos;
    logic              sub_ok;
    logic [LEN_W-1:0]  pub_len;
    t_slot_wr          slot_wr;
    logic [DATA_W-1:0] rd_data;
    logic [LEN_W-1:0]  rd_len;

    // handshakes
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd  <= i_command;
            r_sub  <= i_subscriber;
            r_data <= i_msg_data;
            r_len  <= i_msg_length;
        end
    end

    // head is the oldest held sequence
    assign head_seq = r_tail_seq - SEQ_W'(r_count);
    assign sel_pos  = r_pos[r_sub];
    // distance behind tail, wraps modulo 2^32
    assign lag      = r_tail_seq - sel_pos;
    // reader fell behind the head: its messages were overwritten
    assign stale    = lag > SEQ_W'(r_count);
    assign fix_pos  = stale ? head_seq : sel_pos;
    assign sub_ok   = {1'b0, r_sub} < (SUB_W + 1)'(NUM_SUBS);
    assign pub_len  = clamp_len(r_len);

    // ring depth is a power of two and the tail slot tracks the tail sequence,
    // so a sequence's slot is its low bits
    brwo_slots u_slots (
        .i_clk     (i_clk),
        .i_wr      (slot_wr),
        .i_rd_idx  (fix_pos[SLOT_W-1:0]),
        .o_rd_data (rd_data),
        .o_rd_len  (rd_len)
    );

    // command execution
    always_comb begin
        n_tail_seq = r_tail_seq;
        n_count    = r_count;
        n_pos      = r_pos;
        n_ok       = 1'b0;
        n_out_data = '0;
        n_out_len  = '0;
        n_drop     = '0;
        slot_wr    = '0;

        unique case (r_cmd)
            CMD_PUBLISH: begin
                slot_wr.en   = fire;
                slot_wr.idx  = r_tail_seq[SLOT_W-1:0];
                slot_wr.data = keep_bytes(r_data, pub_len);
                slot_wr.len  = pub_len;
                n_tail_seq   = r_tail_seq + SEQ_W'(1);
                // full ring drops the oldest, count stays at depth
                if (r_count != CNT_W'(DEPTH)) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_ok = 1'b1;
            end
            CMD_BEGIN: begin
                if (sub_ok) begin
                    n_pos[r_sub] = head_seq;
                end
            end
            CMD_NEXT: begin
                if (sub_ok) begin
                    if (stale) begin
                        n_drop = lag - SEQ_W'(r_count);
                    end
                    n_pos[r_sub] = fix_pos;
                    if (fix_pos != r_tail_seq) begin
                        n_ok         = 1'b1;
                        n_out_data   = rd_data;
                        n_out_len    = rd_len;
                        n_pos[r_sub] = fix_pos + SEQ_W'(1);
                    end
                end
            end
            default: begin
                // unused code: no state change, zero result
            end
        endcase
    end

    // ring state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_seq <= SEQ_W'(1);
            r_count    <= '0;
            for (int s = 0; s < NUM_SUBS; s++) begin
                r_pos[s] <= SEQ_W'(1);
            end
        end else if (fire) begin
            r_tail_seq <= n_tail_seq;
            r_count    <= n_count;
            r_pos      <= n_pos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ok       <= n_ok;
            r_out_data <= n_out_data;
            r_out_len  <= n_out_len;
            r_drop     <= n_drop;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_ok         = r_ok;
    assign o_out_data   = r_out_data;
    assign o_out_length = r_out_len;
    assign o_drop_count = r_drop;

endmodule

[tb/brwo_ring_checker.sv]
// checker for the overwriting broadcast ring: mirrors the ring, predicts each reply
// and compares it with what the block returns; depends on brwo_pkg
module brwo_ring_checker
    import brwo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_command,
    input  logic [SUB_W-1:0]  i_subscriber,
    input  logic [DATA_W-1:0] i_msg_data,
    input  logic [LEN_W-1:0]  i_msg_length,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_ok,
    input  logic [DATA_W-1:0] i_out_data,
    input  logic [LEN_W-1:0]  i_out_length,
    input  logic [SEQ_W-1:0]  i_drop_count,
    output int                o_fail_count,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  drops;
    } t_ring_reply;

    // mirror of the ring
    logic [DATA_W-1:0] mirror_word [DEPTH];
    logic [LEN_W-1:0]  mirror_len [DEPTH];
    logic [SEQ_W-1:0]  mirror_head;
    logic [SEQ_W-1:0]  mirror_tail;
    logic [SEQ_W-1:0]  mirror_pos [NUM_SUBS];
    int unsigned       next_slot;

    t_ring_reply awaited_replies[$];
    int          fails = 0;
    int          waiting = 0;

    assign o_fail_count  = fails;
    assign o_outstanding = waiting;

    // applies one command to the mirror and returns the reply it must produce
    function automatic t_ring_reply ring_execute(input logic [1:0]        cmd,
                                                 input logic [SUB_W-1:0]  sub,
                                                 input logic [DATA_W-1:0] word,
                                                 input logic [LEN_W-1:0]  len_in);
        t_ring_reply       r;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] mask;
        logic [SEQ_W-1:0]  pos;
        logic [SEQ_W-1:0]  lag;
        logic [SEQ_W-1:0]  held;
        logic [SEQ_W-1:0]  back;
        int unsigned       slot;
        r = '0;
        case (cmd)
            CMD_PUBLISH: begin
                len  = (len_in > LEN_W'(MAX_MSG_BYTES)) ? LEN_W'(MAX_MSG_BYTES) : len_in;
                mask = (len >= 8) ? '1 : ((DATA_W'(1) << (8 * len)) - DATA_W'(1));
                // full ring drops the oldest message
                if (mirror_tail - mirror_head >= SEQ_W'(DEPTH)) begin
                    mirror_head = mirror_head + 1;
                end
                mirror_word[next_slot] = word & mask;
                mirror_len[next_slot]  = len;
                mirror_tail = mirror_tail + 1;
                next_slot   = (next_slot + 1) % DEPTH;
                r.ok = 1'b1;
            end
            CMD_BEGIN: begin
                if (sub < NUM_SUBS) begin
                    mirror_pos[sub] = mirror_head;
                end
            end
            CMD_NEXT: begin
                if (sub < NUM_SUBS) begin
                    pos  = mirror_pos[sub];
                    lag  = mirror_tail - pos;
                    held = mirror_tail - mirror_head;
                    // reader fell behind the head: skip ahead and count the loss
                    if (lag > held) begin
                        r.drops = lag - held;
                        pos = mirror_head;
                    end
                    mirror_pos[sub] = pos;
                    if (pos != mirror_tail) begin
                        back = (mirror_tail - pos) % SEQ_W'(DEPTH);
                        slot = (next_slot + DEPTH - int'(back)) % DEPTH;
                        r.ok   = 1'b1;
                        r.data = mirror_word[slot];
                        r.len  = mirror_len[slot];
                        mirror_pos[sub] = pos + 1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fails++;
            $error("%s: expected %0h, actual %0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_ring_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SUBS; k++) begin
                mirror_pos[k] = 1;
            end
            mirror_head = 1;
            mirror_tail = 1;
            next_slot   = 1 % DEPTH;
            awaited_replies.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    fails++;
                    $error("reply with no command pending: ok=%0b data=%0h length=%0d drops=%0d",
                           i_ok, i_out_data, i_out_length, i_drop_count);
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("ok", 64'(want.ok), 64'(i_ok));
                    check_field("out_data", want.data, i_out_data);
                    check_field("out_length", 64'(want.len), 64'(i_out_length));
                    check_field("drop_count", 64'(want.drops), 64'(i_drop_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_replies.push_back(ring_execute(i_command, i_subscriber,
                                                       i_msg_data, i_msg_length));
            end
        end
        waiting = awaited_replies.size();
    end

endmodule

[tb/tb_broadcast_ring_with_overwrite.sv]
// top of the broadcast ring testbench: clock, reset, command stimulus, reply stalls
// and the verdict; depends on brwo_pkg, broadcast_ring_with_overwrite and brwo_ring_checker
module tb_broadcast_ring_with_overwrite;
    timeunit 1ns;
    timeprecision 1ps;
    import brwo_pkg::*;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 1430;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    logic [SUB_W-1:0]  i_subscriber;
    logic [DATA_W-1:0] i_msg_data;
    logic [LEN_W-1:0]  i_msg_length;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_ok;
    logic [DATA_W-1:0] o_out_data;
    logic [LEN_W-1:0]  o_out_length;
    logic [SEQ_W-1:0]  o_drop_count;

    int fail_count;
    int outstanding;
    int send_mode = 0;
    int idle_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    broadcast_ring_with_overwrite uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_subscriber (i_subscriber),
        .i_msg_data   (i_msg_data),
        .i_msg_length (i_msg_length),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ok         (o_ok),
        .o_out_data   (o_out_data),
        .o_out_length (o_out_length),
        .o_drop_count (o_drop_count)
    );

    brwo_ring_checker ring_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_subscriber  (i_subscriber),
        .i_msg_data    (i_msg_data),
        .i_msg_length  (i_msg_length),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_ok          (o_ok),
        .i_out_data    (o_out_data),
        .i_out_length  (o_out_length),
        .i_drop_count  (o_drop_count),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // idle cycles before the next transaction on either side
    // mode 0: back to back, mode 1: a uniformly random gap, mode 2: mostly none with rare gaps
    function automatic int draw_wait(input int mode);
        int w;
        case (mode)
            0: w = 0;
            1: w = $urandom_range(0, 13);
            default: w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
        return w;
    endfunction

    // offers one command transaction and returns at the falling edge after it was taken
    task automatic send_command(input logic [1:0]        cmd,
                                input logic [SUB_W-1:0]  sub,
                                input logic [DATA_W-1:0] word,
                                input logic [LEN_W-1:0]  len);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        // valid stays high without a dip when items follow back to back
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_subscriber <= sub;
        i_msg_data   <= word;
        i_msg_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // command stimulus and verdict
    initial begin
        int               pick;
        int               mix;
        logic [1:0]       cmd;
        logic [LEN_W-1:0] len;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_PUBLISH;
        i_subscriber = '0;
        i_msg_data   = '0;
        i_msg_length = '0;
        mix          = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part
        send_command(CMD_NEXT, 2'd3, '0, '0);              // next on an empty ring
        send_command(CMD_UNUSED, 2'd3, '1, 4'hf);          // unknown command is ignored
        send_command(CMD_PUBLISH, 2'd0, '1, 4'd8);         // full width word
        send_command(CMD_PUBLISH, 2'd1, '1, 4'd0);         // zero length stores zero
        send_command(CMD_PUBLISH, 2'd2, '1, 4'd15);        // long length is clamped
        send_command(CMD_PUBLISH, 2'd3, {$urandom, $urandom}, 4'd9);
        send_command(CMD_PUBLISH, 2'd0, '0, 4'd1);
        send_command(CMD_PUBLISH, 2'd0, 64'h8877_6655_4433_2211, 4'd3);
        // drain subscriber 0, the last one finds nothing
        repeat (7) send_command(CMD_NEXT, 2'd0, '1, 4'hf);
        send_command(CMD_BEGIN, 2'd1, '0, '0);
        send_command(CMD_NEXT, 2'd1, '0, '0);
        send_command(CMD_BEGIN, 2'd2, '1, 4'hf);
        send_command(CMD_BEGIN, 2'd3, '0, '0);
        send_command(CMD_NEXT, 2'd2, '0, '0);

        // random part in blocks: publish-heavy blocks overrun slow readers,
        // read-heavy blocks drain the ring and hit the empty case
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                mix       = $urandom_range(0, 3);
                send_mode = $urandom_range(0, 2);
            end
            pick = $urandom_range(0, 99);
            case (mix)
                0: cmd = (pick < 80) ? CMD_PUBLISH : (pick < 95) ? CMD_NEXT :
                         (pick < 98) ? CMD_BEGIN : CMD_UNUSED;
                1: cmd = (pick < 20) ? CMD_PUBLISH : (pick < 95) ? CMD_NEXT :
                         (pick < 98) ? CMD_BEGIN : CMD_UNUSED;
                default: cmd = (pick < 45) ? CMD_PUBLISH : (pick < 90) ? CMD_NEXT :
                               (pick < 97) ? CMD_BEGIN : CMD_UNUSED;
            endcase
            len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                              : LEN_W'($urandom_range(0, 8));
            send_command(cmd, SUB_W'($urandom_range(0, 3)), {$urandom, $urandom}, len);
        end
        i_in_valid <= 1'b0;

        // let every reply come back, then watch a while for strays
        wait (outstanding == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_broadcast_ring_with_overwrite: done, clean");
        end else begin
            $display("tb_broadcast_ring_with_overwrite: done, errors");
        end
        $finish;
    end

    // reply side: random stall before each reply transaction, with two long
    // hold-offs so the block fills up and stalls its command input
    initial begin
        int wait_cyc;
        int taken;
        int rx_mode;
        i_out_stall = 1'b0;
        taken       = 0;
        rx_mode     = 1;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 40 == 0) begin
                rx_mode = $urandom_range(0, 2);
            end
            if (taken == 300 || taken == 900) begin
                wait_cyc = 70 + $urandom_range(0, 30);
            end else begin
                wait_cyc = draw_wait(rx_mode);
            end
            if (wait_cyc > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cyc) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            taken++;
            @(negedge i_clk);
        end
    end

    // hang detection: counts cycles in which neither channel moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("tb_broadcast_ring_with_overwrite: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

[broadcast_ring_with_overwrite.f]
rtl/brwo_pkg.sv
rtl/brwo_slots.sv
rtl/broadcast_ring_with_overwrite.sv
tb/brwo_ring_checker.sv
tb/tb_broadcast_ring_with_overwrite.sv
